// ===== src/weighted_response_accumulator_top_defines.svh =====
// ----------------------------------------------------------------------------
// Weighted response accumulator assertion macros
// Shared concurrent assertion shorthands for the accumulator RTL.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_RESPONSE_ACCUMULATOR_TOP_DEFINES_SVH
`define WEIGHTED_RESPONSE_ACCUMULATOR_TOP_DEFINES_SVH

// Checked property, masked while reset is high.
`define WRA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property, also during reset.
`define WRA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/wra_pkg.sv =====
// ----------------------------------------------------------------------------
// Weighted response accumulator package
// Shared types, codes and sizing defaults.
// ----------------------------------------------------------------------------
package wra_pkg;

   localparam int SAMPLES_DEF    = 16;
   localparam int MODES_DEF      = 8;
   localparam int STAMP_SIZE_DEF = 9;

   localparam int COUNT_W  = 20;
   localparam int WSUM_W   = 48;
   localparam int RSUM_W   = 64;
   localparam int FCOUNT_W = 20;
   localparam int GFRAC_W  = 17;
   localparam int THRESH_W = FCOUNT_W + GFRAC_W;

   localparam logic [1:0] OP_ADD_RESP = 2'd0;
   localparam logic [1:0] OP_ADD_SUP  = 2'd1;
   localparam logic [1:0] OP_READ     = 2'd2;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_BAD_INDEX = 2'd1;
   localparam logic [1:0] STAT_OVERFLOW  = 2'd2;

   localparam logic CSR_FRAME_COUNT   = 1'b0;
   localparam logic CSR_GOOD_FRACTION = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADDR,
      ST_READ,
      ST_EXEC,
      ST_DIV
   } state_type;

   typedef struct packed {
      logic clear;
      logic capture;
      logic calc;
      logic read;
      logic exec;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic need_div;
      logic div_done;
   } stat_type;

endpackage

// ===== src/wra_div.sv =====
// ----------------------------------------------------------------------------
// Accumulator divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wra_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [wra_pkg::RSUM_W-1:0]   dividend,
   input  logic [wra_pkg::WSUM_W-1:0]   divisor,
   output logic                         done,
   output logic [wra_pkg::RSUM_W-1:0]   quotient
);
   import wra_pkg::*;

   localparam int STEP_W = $clog2(RSUM_W);

   logic [WSUM_W-1:0] rem_ff, rem_in;
   logic [RSUM_W-1:0] quo_ff, quo_in;
   logic [WSUM_W-1:0] dvs_ff;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [WSUM_W:0]   shifted;
   logic [WSUM_W:0]   diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[RSUM_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         step_in = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = diff[WSUM_W-1:0];
            quo_in = {quo_ff[RSUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[WSUM_W-1:0];
            quo_in = {quo_ff[RSUM_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(RSUM_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== src/wra_dp.sv =====
// ----------------------------------------------------------------------------
// Accumulator datapath
// Sum memories, address math, saturating updates, support test, divider.
// ----------------------------------------------------------------------------
module wra_dp #(
   parameter int SAMPLES    = wra_pkg::SAMPLES_DEF,
   parameter int MODES      = wra_pkg::MODES_DEF,
   parameter int STAMP_SIZE = wra_pkg::STAMP_SIZE_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  wra_pkg::cmd_type               cmd,
   output wra_pkg::stat_type              stat,
   input  logic [wra_pkg::FCOUNT_W-1:0]   frame_count,
   input  logic [wra_pkg::GFRAC_W-1:0]    good_fraction,
   input  logic [1:0]                     req_op,
   input  logic [3:0]                     req_sample_index,
   input  logic [2:0]                     req_mode_index,
   input  logic [6:0]                     req_pixel_index,
   input  logic signed [31:0]             req_frame_weight,
   input  logic signed [31:0]             req_contribution,
   input  logic                           req_pixel_valid,
   output logic                           rsp_strobe,
   output logic [1:0]                     rsp_status,
   output logic signed [31:0]             rsp_response_value,
   output logic                           rsp_response_valid
);
   import wra_pkg::*;

   localparam int PIXELS     = STAMP_SIZE * STAMP_SIZE;
   localparam int SUP_DEPTH  = SAMPLES * PIXELS;
   localparam int RESP_DEPTH = SAMPLES * MODES * PIXELS;
   localparam int RAW = (RESP_DEPTH > 1) ? $clog2(RESP_DEPTH) : 1;
   localparam int SAW = (SUP_DEPTH > 1) ? $clog2(SUP_DEPTH) : 1;
   localparam int CW  = $clog2(RESP_DEPTH + 1);
   localparam int SUP_W = WSUM_W + COUNT_W;

   localparam logic [RSUM_W-1:0] RSUM_MAX = {1'b0, {(RSUM_W-1){1'b1}}};
   localparam logic [RSUM_W-1:0] RSUM_MIN = {1'b1, {(RSUM_W-1){1'b0}}};
   localparam logic [WSUM_W-1:0] WSUM_MAX = {1'b0, {(WSUM_W-1){1'b1}}};
   localparam logic [WSUM_W-1:0] WSUM_MIN = {1'b1, {(WSUM_W-1){1'b0}}};

   // captured request
   logic [1:0]         op_ff;
   logic [3:0]         sample_ff;
   logic [2:0]         mode_ff;
   logic [6:0]         pixel_ff;
   logic signed [31:0] weight_ff;
   logic signed [31:0] contrib_ff;
   logic               pvalid_ff;

   // address stage
   logic               bad_ff, bad_in;
   logic [RAW-1:0]     ridx_ff;
   logic [SAW-1:0]     sidx_ff;
   logic [RSUM_W-1:0]  prod_ff;
   logic [31:0]        sidx_full, ridx_full;

   // memories and read data
   logic [RSUM_W-1:0]  resp_mem [RESP_DEPTH];
   logic [SUP_W-1:0]   sup_mem  [SUP_DEPTH];
   logic [RSUM_W-1:0]  resp_rd_ff;
   logic [SUP_W-1:0]   sup_rd_ff;

   logic [CW-1:0]      clr_ff;
   logic [THRESH_W-1:0] thresh_ff;

   logic [WSUM_W-1:0]  ws_rd;
   logic [COUNT_W-1:0] cnt_rd;
   logic [RSUM_W:0]    rsum_ext;
   logic [RSUM_W-1:0]  rsum_sat;
   logic [WSUM_W:0]    wsum_ext;
   logic [WSUM_W-1:0]  wsum_sat;
   logic               cnt_full;
   logic               enough;
   logic               need_div;

   logic               resp_we, sup_we, sup_clr;
   logic [RAW-1:0]     resp_waddr;
   logic [SAW-1:0]     sup_waddr;
   logic [RSUM_W-1:0]  resp_wdata;
   logic [SUP_W-1:0]   sup_wdata;

   logic [RSUM_W-1:0]  dividend;
   logic [WSUM_W-1:0]  divisor;
   logic               div_done;
   logic [RSUM_W-1:0]  quotient;
   logic               neg_ff;
   logic [31:0]        qsat;

   logic               strobe_ff, strobe_in;
   logic [1:0]         status_ff, status_in;
   logic [31:0]        value_ff, value_in;
   logic               valid_ff, valid_in;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= req_op;
         sample_ff  <= req_sample_index;
         mode_ff    <= req_mode_index;
         pixel_ff   <= req_pixel_index;
         weight_ff  <= req_frame_weight;
         contrib_ff <= req_contribution;
         pvalid_ff  <= req_pixel_valid;
      end
   end

   always_comb begin
      sidx_full = 32'(sample_ff) * 32'(PIXELS) + 32'(pixel_ff);
      ridx_full = (32'(sample_ff) * 32'(MODES) + 32'(mode_ff)) * 32'(PIXELS)
                  + 32'(pixel_ff);
      bad_in = (op_ff != OP_ADD_RESP && op_ff != OP_ADD_SUP && op_ff != OP_READ)
               || 32'(sample_ff) >= 32'(SAMPLES)
               || 32'(pixel_ff) >= 32'(PIXELS)
               || (op_ff != OP_ADD_SUP && 32'(mode_ff) >= 32'(MODES));
   end

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         bad_ff  <= bad_in;
         ridx_ff <= ridx_full[RAW-1:0];
         sidx_ff <= sidx_full[SAW-1:0];
         prod_ff <= RSUM_W'(weight_ff * contrib_ff);
      end
      thresh_ff <= THRESH_W'(good_fraction) * THRESH_W'(frame_count);
   end

   // clear sweep counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   always_comb begin
      ws_rd  = sup_rd_ff[SUP_W-1:COUNT_W];
      cnt_rd = sup_rd_ff[COUNT_W-1:0];

      rsum_ext = {resp_rd_ff[RSUM_W-1], resp_rd_ff} + {prod_ff[RSUM_W-1], prod_ff};
      if (rsum_ext[RSUM_W] != rsum_ext[RSUM_W-1]) begin
         rsum_sat = rsum_ext[RSUM_W] ? RSUM_MIN : RSUM_MAX;
      end else begin
         rsum_sat = rsum_ext[RSUM_W-1:0];
      end

      wsum_ext = {ws_rd[WSUM_W-1], ws_rd}
                 + {{(WSUM_W-31){weight_ff[31]}}, weight_ff};
      if (wsum_ext[WSUM_W] != wsum_ext[WSUM_W-1]) begin
         wsum_sat = wsum_ext[WSUM_W] ? WSUM_MIN : WSUM_MAX;
      end else begin
         wsum_sat = wsum_ext[WSUM_W-1:0];
      end

      cnt_full = (cnt_rd == {COUNT_W{1'b1}});
      enough   = (cnt_rd != '0)
                 && ({1'b0, cnt_rd, 16'd0} >= THRESH_W'(thresh_ff));
      need_div = !bad_ff && op_ff == OP_READ && enough && ws_rd != '0;

      dividend = resp_rd_ff[RSUM_W-1] ? (RSUM_W'(0) - resp_rd_ff) : resp_rd_ff;
      divisor  = ws_rd[WSUM_W-1] ? (WSUM_W'(0) - ws_rd) : ws_rd;

      sup_clr    = cmd.clear && (32'(clr_ff) < 32'(SUP_DEPTH));
      resp_we    = cmd.clear || (cmd.exec && !bad_ff && op_ff == OP_ADD_RESP);
      resp_waddr = cmd.clear ? clr_ff[RAW-1:0] : ridx_ff;
      resp_wdata = cmd.clear ? '0 : rsum_sat;
      sup_we     = sup_clr || (cmd.exec && !bad_ff && op_ff == OP_ADD_SUP
                               && pvalid_ff && !cnt_full);
      sup_waddr  = cmd.clear ? clr_ff[SAW-1:0] : sidx_ff;
      sup_wdata  = cmd.clear ? '0 : {wsum_sat, cnt_rd + 1'b1};
   end

   always_ff @(posedge clock) begin
      if (resp_we) begin
         resp_mem[resp_waddr] <= resp_wdata;
      end
      if (cmd.read) begin
         resp_rd_ff <= resp_mem[ridx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (sup_we) begin
         sup_mem[sup_waddr] <= sup_wdata;
      end
      if (cmd.read) begin
         sup_rd_ff <= sup_mem[sidx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && need_div) begin
         neg_ff <= resp_rd_ff[RSUM_W-1] ^ ws_rd[WSUM_W-1];
      end
   end

   wra_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.exec && need_div),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   // saturate to signed Q16.16
   always_comb begin
      if (neg_ff) begin
         qsat = (quotient >= RSUM_W'(32'h8000_0000)) ? 32'h8000_0000
                                                    : 32'(32'd0 - quotient[31:0]);
      end else begin
         qsat = (quotient >= RSUM_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                                                    : quotient[31:0];
      end
   end

   always_comb begin
      strobe_in = 1'b0;
      status_in = status_ff;
      value_in  = value_ff;
      valid_in  = valid_ff;
      if (div_done) begin
         strobe_in = 1'b1;
         status_in = STAT_OK;
         value_in  = qsat;
         valid_in  = 1'b1;
      end else if (cmd.exec && !need_div) begin
         strobe_in = 1'b1;
         value_in  = '0;
         valid_in  = 1'b0;
         if (bad_ff) begin
            status_in = STAT_BAD_INDEX;
         end else if (op_ff == OP_ADD_SUP && pvalid_ff && cnt_full) begin
            status_in = STAT_OVERFLOW;
         end else begin
            status_in = STAT_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      value_ff  <= value_in;
      valid_ff  <= valid_in;
   end

   assign stat.clear_last = (clr_ff == CW'(RESP_DEPTH - 1));
   assign stat.need_div   = need_div;
   assign stat.div_done   = div_done;

   assign rsp_strobe         = strobe_ff;
   assign rsp_status         = status_ff;
   assign rsp_response_value = value_ff;
   assign rsp_response_valid = valid_ff;

endmodule

// ===== src/wra_ctrl.sv =====
// ----------------------------------------------------------------------------
// Accumulator controller
// Sequences clear sweep, address, memory read, execute and divide steps.
// ----------------------------------------------------------------------------
module wra_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   output wra_pkg::cmd_type   cmd,
   input  wra_pkg::stat_type  stat
);
   import wra_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cmd.capture = start;
            if (start) begin
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            cmd.calc = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = stat.need_div ? ST_DIV : ST_IDLE;
         end
         ST_DIV: begin
            if (stat.div_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== src/weighted_response_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// Weighted response accumulator
// Per-pixel weighted response sums with frame support and normalized reads.
// ----------------------------------------------------------------------------
// Usage: after reset the block sweeps its sum memories to zero, one entry per
// cycle, across SAMPLES*MODES*STAMP_SIZE^2 response entries (10368 at the
// defaults); busy stays high for that whole sweep. Then a beat is taken when
// start is high and busy low. Add-response and add-support beats step through
// capture, address math with the 32x32 multiply, memory read, then update and
// write back. A read without support takes the same steps; a supported read
// then runs the 64 steps of the bit-serial 64/48 divider and hands the
// quotient back. Exactly one result
// comes back per beat, on rsp_strobe for a single cycle, and there is no
// back-pressure: the receiver must take it when it appears. The CSR port
// (frame_count at index 0, good_fraction at index 1) may be written while the
// block is idle.
// ----------------------------------------------------------------------------
`include "weighted_response_accumulator_top_defines.svh"

module weighted_response_accumulator_top #(
   parameter int SAMPLES    = wra_pkg::SAMPLES_DEF,
   parameter int MODES      = wra_pkg::MODES_DEF,
   parameter int STAMP_SIZE = wra_pkg::STAMP_SIZE_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // request beat
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_op,
   input  logic [3:0]         req_sample_index,
   input  logic [2:0]         req_mode_index,
   input  logic [6:0]         req_pixel_index,
   input  logic signed [31:0] req_frame_weight,
   input  logic signed [31:0] req_contribution,
   input  logic               req_pixel_valid,
   // response beat
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_response_value,
   output logic               rsp_response_valid,
   // CSR write port
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [19:0]        csr_wdata
);
   import wra_pkg::*;

   logic [FCOUNT_W-1:0] frame_count_ff;
   logic [GFRAC_W-1:0]  good_fraction_ff;
   cmd_type             cmd;
   stat_type            stat;

   // config registers; data bits above the register width are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff   <= FCOUNT_W'(1);
         good_fraction_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_COUNT:   frame_count_ff   <= csr_wdata[FCOUNT_W-1:0];
            CSR_GOOD_FRACTION: good_fraction_ff <= csr_wdata[GFRAC_W-1:0];
            default: ;
         endcase
      end
   end

   wra_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .stat  (stat)
   );

   wra_dp #(
      .SAMPLES    (SAMPLES),
      .MODES      (MODES),
      .STAMP_SIZE (STAMP_SIZE)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .frame_count        (frame_count_ff),
      .good_fraction      (good_fraction_ff),
      .req_op             (req_op),
      .req_sample_index   (req_sample_index),
      .req_mode_index     (req_mode_index),
      .req_pixel_index    (req_pixel_index),
      .req_frame_weight   (req_frame_weight),
      .req_contribution   (req_contribution),
      .req_pixel_valid    (req_pixel_valid),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_response_value (rsp_response_value),
      .rsp_response_valid (rsp_response_valid)
   );

   // reset always lands in the clear sweep
   `WRA_ASSERT_ALWAYS(a_busy_after_reset, clock, reset |=> busy, "not busy after reset")
   // an accepted beat keeps the block busy until its result
   `WRA_ASSERT(a_busy_on_accept, clock, reset, (start && !busy) |=> busy, "accept not held")
   // every beat runs through address, read and execute states before its result, so results never come back to back
   `WRA_ASSERT(a_no_double_strobe, clock, reset, rsp_strobe |=> !rsp_strobe, "double strobe")
   // a valid response only comes with ok status
   `WRA_ASSERT(a_valid_ok, clock, reset,
      (rsp_strobe && rsp_response_valid) |-> (rsp_status == STAT_OK), "valid with bad status")

endmodule

// ===== tb/weighted_response_accumulator_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Weighted response accumulator testbench
// Drives directed and random command beats through the accumulator, keeps a
// shadow copy of the response, weight and count stores, and checks every
// response beat field by field against the shadow prediction or a typed-in answer.
// ----------------------------------------------------------------------------
module weighted_response_accumulator_top_tb;
   import wra_pkg::*;

   localparam int PIX      = STAMP_SIZE_DEF * STAMP_SIZE_DEF;
   localparam int NSAMP    = SAMPLES_DEF;
   localparam int NMODE    = MODES_DEF;
   localparam int N_RANDOM = 1030;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] value;
      logic               valid;
   } answer_t;

   // One row of the directed table. pin=1 means the answer is typed in.
   typedef struct packed {
      logic [1:0]  op;
      logic [3:0]  sample;
      logic [2:0]  mode;
      logic [6:0]  pixel;
      logic [31:0] weight;
      logic [31:0] contrib;
      logic        pvalid;
      logic        pin;
      answer_t     ans;
   } row_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_op = '0;
   logic [3:0]         req_sample_index = '0;
   logic [2:0]         req_mode_index = '0;
   logic [6:0]         req_pixel_index = '0;
   logic signed [31:0] req_frame_weight = '0;
   logic signed [31:0] req_contribution = '0;
   logic               req_pixel_valid = 1'b0;
   logic               rsp_strobe;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_response_value;
   logic               rsp_response_valid;
   logic               csr_we = 1'b0;
   logic               csr_index = CSR_FRAME_COUNT;
   logic [19:0]        csr_wdata = '0;

   // typed-in answer travels with the beat so the monitor sees it in step
   logic               pin_on = 1'b0;
   answer_t            pin_ans = '0;

   weighted_response_accumulator_top dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Shadow stores and registers
   // ---------------------------------------------------------------------
   logic signed [63:0] shadow_rsum [NSAMP*NMODE*PIX];
   logic signed [47:0] shadow_wsum [NSAMP*PIX];
   logic [19:0]        shadow_count [NSAMP*PIX];
   logic [19:0]        shadow_frames;
   logic [16:0]        shadow_fraction;

   answer_t pending_answers [$];
   int      mismatch_count = 0;
   int      beats_checked  = 0;
   int      supported_reads = 0;
   int      errors_seen    = 0;

   // Apply one command to the shadow stores; return the answer it gives.
   function automatic answer_t apply_command(logic [1:0] op, logic [3:0] s,
         logic [2:0] m, logic [6:0] p, logic signed [31:0] fw,
         logic signed [31:0] ct, logic pv);
      answer_t            a;
      int                 sidx, ridx;
      logic signed [63:0] prod, rs;
      logic signed [64:0] s65;
      logic signed [47:0] ws;
      logic signed [48:0] w49;
      logic [63:0]        mr, mw, q, lhs, rhs;
      a = '0;
      if (op == 2'd3 || s >= NSAMP || p >= PIX || (op != OP_ADD_SUP && m >= NMODE)) begin
         a.status = STAT_BAD_INDEX;
         return a;
      end
      sidx = s * PIX + p;
      ridx = (s * NMODE + m) * PIX + p;
      case (op)
         OP_ADD_RESP: begin
            prod = fw * ct;
            s65 = shadow_rsum[ridx] + prod;
            if (s65[64] != s65[63])
               shadow_rsum[ridx] = s65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            else
               shadow_rsum[ridx] = s65[63:0];
         end
         OP_ADD_SUP: begin
            if (pv) begin
               if (shadow_count[sidx] == 20'hFFFFF) begin
                  a.status = STAT_OVERFLOW;
               end else begin
                  w49 = shadow_wsum[sidx] + fw;
                  if (w49[48] != w49[47])
                     shadow_wsum[sidx] = w49[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
                  else
                     shadow_wsum[sidx] = w49[47:0];
                  shadow_count[sidx] = shadow_count[sidx] + 20'd1;
               end
            end
         end
         default: begin
            ws  = shadow_wsum[sidx];
            lhs = 64'(shadow_count[sidx]) << 16;
            rhs = 64'(shadow_fraction) * 64'(shadow_frames);
            if (shadow_count[sidx] != 0 && lhs >= rhs && ws != 0) begin
               rs = shadow_rsum[ridx];
               mr = rs[63] ? -rs : rs;
               mw = ws[47] ? -64'(ws) : 64'(ws);
               q  = mr / mw;
               if (rs[63] != ws[47])
                  a.value = (q >= 64'h8000_0000) ? 32'h8000_0000 : -q[31:0];
               else
                  a.value = (q >= 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
               a.valid = 1'b1;
            end
         end
      endcase
      return a;
   endfunction

   // ---------------------------------------------------------------------
   // Monitor: everything is sampled at the edge, before any NBA lands
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      answer_t pred, want;
      if (reset) begin
         for (int i = 0; i < NSAMP*NMODE*PIX; i++) shadow_rsum[i] = '0;
         for (int i = 0; i < NSAMP*PIX; i++) begin
            shadow_wsum[i]  = '0;
            shadow_count[i] = '0;
         end
         shadow_frames   = 20'd1;
         shadow_fraction = 17'd0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_FRAME_COUNT) shadow_frames = csr_wdata;
            else shadow_fraction = csr_wdata[16:0];
         end
         if (start && !busy) begin
            pred = apply_command(req_op, req_sample_index, req_mode_index,
                                 req_pixel_index, req_frame_weight,
                                 req_contribution, req_pixel_valid);
            pending_answers.push_back(pin_on ? pin_ans : pred);
         end
         if (rsp_strobe) begin
            beats_checked++;
            if (rsp_response_valid) supported_reads++;
            if (rsp_status != STAT_OK) errors_seen++;
            if (pending_answers.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: response beat with nothing expected", $realtime);
            end else begin
               want = pending_answers.pop_front();
               if (rsp_status !== want.status || rsp_response_value !== want.value ||
                     rsp_response_valid !== want.valid) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: exp status %0d value %h valid %b, got %0d %h %b",
                              $realtime, want.status, want.value, want.valid,
                              rsp_status, rsp_response_value, rsp_response_valid);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Driver
   // ---------------------------------------------------------------------
   int idle_pct = 0;

   // Put one command on the request ports and hold it until taken.
   task automatic send_command(row_t r);
      req_op           <= r.op;
      req_sample_index <= r.sample;
      req_mode_index   <= r.mode;
      req_pixel_index  <= r.pixel;
      req_frame_weight <= r.weight;
      req_contribution <= r.contrib;
      req_pixel_valid  <= r.pvalid;
      pin_on           <= r.pin;
      pin_ans          <= r.ans;
      start            <= 1'b1;
      do @(posedge clock); while (busy);
      // random gap after the beat
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   // Hold off until every expected answer has come back. The first edge
   // lets the monitor log a beat taken at the edge we were called on.
   task automatic drain_answers();
      start <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [19:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Random command: mostly a few hot pixels so reads find support.
   function automatic row_t random_command();
      row_t r;
      int   k;
      r = '0;
      k = $urandom_range(99);
      r.op     = (k < 35) ? OP_ADD_RESP : (k < 70) ? OP_ADD_SUP : (k < 96) ? OP_READ : 2'd3;
      r.sample = ($urandom_range(9) < 8) ? 4'($urandom_range(2)) : 4'($urandom);
      r.mode   = ($urandom_range(9) < 8) ? 3'($urandom_range(1)) : 3'($urandom);
      if ($urandom_range(19) == 0) r.pixel = 7'($urandom);
      else if ($urandom_range(9) < 8) r.pixel = 7'($urandom_range(3));
      else r.pixel = 7'($urandom_range(PIX - 1));
      r.weight  = ($urandom_range(9) == 0) ? $urandom
                : 32'(signed'($urandom_range(262144)) - 65536);
      r.contrib = ($urandom_range(9) == 0) ? $urandom
                : 32'(signed'($urandom_range(1 << 22)) - (1 << 21));
      r.pvalid  = ($urandom_range(9) < 8);
      return r;
   endfunction

   // Directed rows, run just after reset with frame_count 1, fraction 0.
   localparam answer_t OK0  = '{STAT_OK, 32'sd0, 1'b0};
   localparam answer_t BAD0 = '{STAT_BAD_INDEX, 32'sd0, 1'b0};
   localparam int N_DIRECTED = 18;
   row_t directed [N_DIRECTED] = '{
      // read before anything is stored: no support
      '{OP_READ,     4'd0,  3'd0, 7'd0,  32'h0,        32'h0,        1'b0, 1'b1, OK0},
      // out-of-range pixel, unknown op
      '{OP_ADD_RESP, 4'd0,  3'd0, 7'd81, 32'h10000,    32'h10000,    1'b0, 1'b1, BAD0},
      '{OP_READ,     4'd15, 3'd7, 7'd127,32'h10000,    32'h10000,    1'b1, 1'b1, BAD0},
      '{OP_ADD_SUP,  4'd0,  3'd0, 7'd90, 32'h10000,    32'h0,        1'b1, 1'b1, BAD0},
      '{2'd3,        4'd0,  3'd0, 7'd0,  32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1, BAD0},
      // weight 1.0, response 3.0 -> read gives 3.0
      '{OP_ADD_SUP,  4'd0,  3'd5, 7'd0,  32'h10000,    32'h0,        1'b1, 1'b1, OK0},
      '{OP_ADD_SUP,  4'd0,  3'd0, 7'd0,  32'h7FFFFFFF, 32'h0,        1'b0, 1'b1, OK0},
      '{OP_ADD_RESP, 4'd0,  3'd0, 7'd0,  32'h10000,    32'h30000,    1'b0, 1'b1, OK0},
      '{OP_READ,     4'd0,  3'd0, 7'd0,  32'h0,        32'h0,        1'b0, 1'b1,
        '{STAT_OK, 32'sh30000, 1'b1}},
      // extreme products saturate the response sum; tiny weight -> clamp high
      '{OP_ADD_RESP, 4'd15, 3'd7, 7'd80, 32'h80000000, 32'h80000000, 1'b1, 1'b0, OK0},
      '{OP_ADD_RESP, 4'd15, 3'd7, 7'd80, 32'h80000000, 32'h80000000, 1'b1, 1'b0, OK0},
      '{OP_ADD_SUP,  4'd15, 3'd0, 7'd80, 32'h1,        32'h0,        1'b1, 1'b0, OK0},
      '{OP_READ,     4'd15, 3'd7, 7'd80, 32'h0,        32'h0,        1'b0, 1'b1,
        '{STAT_OK, 32'sh7FFFFFFF, 1'b1}},
      // negative product over positive weight -> clamp low
      '{OP_ADD_RESP, 4'd15, 3'd6, 7'd80, 32'h7FFFFFFF, 32'h80000000, 1'b0, 1'b0, OK0},
      '{OP_READ,     4'd15, 3'd6, 7'd80, 32'h0,        32'h0,        1'b0, 1'b1,
        '{STAT_OK, 32'sh80000000, 1'b1}},
      // weights cancel to zero: counted but not valid
      '{OP_ADD_SUP,  4'd1,  3'd0, 7'd5,  32'h10000,    32'h0,        1'b1, 1'b0, OK0},
      '{OP_ADD_SUP,  4'd1,  3'd0, 7'd5,  32'hFFFF0000, 32'h0,        1'b1, 1'b0, OK0},
      '{OP_READ,     4'd1,  3'd3, 7'd5,  32'h0,        32'h0,        1'b0, 1'b1, OK0}
   };

   // frame_count / good_fraction per random phase, extremes included
   localparam int N_PHASES = 6;
   int phase_frames [N_PHASES]   = '{1, 4, 0, 1048575, 2, 3};
   int phase_fraction [N_PHASES] = '{0, 32768, 65536, 1, 65536, 131071};
   int phase_idle [N_PHASES]     = '{0, 52, 0, 52, 35, 35};

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // ride out the store-clearing sweep
      do @(posedge clock); while (busy);

      foreach (directed[i]) send_command(directed[i]);
      drain_answers();

      for (int ph = 0; ph < N_PHASES; ph++) begin
         write_csr(CSR_FRAME_COUNT, 20'(phase_frames[ph]));
         write_csr(CSR_GOOD_FRACTION, 20'(phase_fraction[ph]));
         idle_pct = phase_idle[ph];
         for (int n = 0; n < N_RANDOM / N_PHASES; n++) begin
            send_command(random_command());
            // sender holds off once mid-phase until all answers are back
            if (n == 60) drain_answers();
         end
         drain_answers();
      end

      repeat (80) @(posedge clock);
      if (pending_answers.size() != 0) mismatch_count++;
      $display("%0d response beats checked: %0d supported reads, %0d error statuses,",
               beats_checked, supported_reads, errors_seen);
      $display("over %0d register settings with idle sender phases", N_PHASES);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // watchdog
   initial begin
      #4000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
